[rtl/asc_pkg.sv]
// Shared types and constants of the accelerometer step counter.
// Holds sizes, reset values, register and axis codes, and lane structs.
// Depends on nothing; every RTL file of the block uses it.
`default_nettype none

package asc_pkg;

  // Moving-sum smoother depth; a power of two so the divide is a shift
  localparam int unsigned SMOOTH_TAPS  = 4;
  localparam int unsigned SMOOTH_SHIFT = $clog2(SMOOTH_TAPS);
  localparam int unsigned TAP_IDX_W    = SMOOTH_SHIFT;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = SAMPLE_W + SMOOTH_SHIFT;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned IDLE_W   = 8;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [REG_W-1:0]           cfg_word_t;

  localparam sample_t SAMPLE_MIN = sample_t'(-32768);
  localparam sample_t SAMPLE_MAX = sample_t'(32767);

  // Register reset values
  localparam cfg_word_t WINDOW_LENGTH_RST  = 16'd100;
  localparam cfg_word_t PRECISION_X_RST    = 16'd1500;
  localparam cfg_word_t PRECISION_Y_RST    = 16'd800;
  localparam cfg_word_t PRECISION_Z_RST    = 16'd800;
  localparam cfg_word_t ACTIVE_MINIMUM_RST = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 3'd0,
    CFG_PRECISION_X    = 3'd1,
    CFG_PRECISION_Y    = 3'd2,
    CFG_PRECISION_Z    = 3'd3,
    CFG_ACTIVE_MINIMUM = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } axis_e;

  // Control shared by all lanes
  typedef struct packed {
    logic                 load_s1;  // new sample enters the smoother
    logic                 load_s2;  // smoothed word enters window and gate
    logic                 roll;     // window rolls over with this word
    logic [TAP_IDX_W-1:0] wr_idx;   // smoother tap to overwrite
  } lane_ctl_t;

  // Per-axis state seen by the merge stage
  typedef struct packed {
    sample_t win_max;
    sample_t win_min;
    sample_t thr;
    sample_t gate_cur;
    sample_t gate_prev;
  } lane_state_t;

endpackage

`default_nettype wire

[rtl/asc_lane.sv]
// One axis lane: running-sum smoother, window max/min with threshold, change gate.
// Two stages: smoother sum, then window and gate state. Uses asc_pkg.
`default_nettype none

module asc_lane (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  asc_pkg::lane_ctl_t      ctl_i,
  input  asc_pkg::sample_t        sample_i,
  input  asc_pkg::cfg_word_t      precision_i,
  output asc_pkg::lane_state_t    state_o
);

  asc_pkg::sample_t taps_q [asc_pkg::SMOOTH_TAPS];
  asc_pkg::sum_t    sum_q, sum_d;

  asc_pkg::sample_t max_q, max_d, min_q, min_d, thr_q, thr_d;
  asc_pkg::sample_t gcur_q, gcur_d, gprev_q;

  asc_pkg::sum_t         sum_rnd;
  asc_pkg::sample_t      smp;
  logic signed [asc_pkg::SAMPLE_W:0] mid_sum, mid_adj, diff, mag;
  asc_pkg::sample_t      max_base, min_base;

  // Replace the oldest tap in the running sum
  assign sum_d = sum_q + asc_pkg::sum_t'(sample_i) - asc_pkg::sum_t'(taps_q[ctl_i.wr_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < asc_pkg::SMOOTH_TAPS; i++) begin
        taps_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (ctl_i.load_s1) begin
      taps_q[ctl_i.wr_idx] <= sample_i;
      sum_q                <= sum_d;
    end
  end

  // Divide the sum by the tap count, truncating toward zero
  always_comb begin
    sum_rnd = sum_q + (sum_q[asc_pkg::SUM_W-1] ?
                       asc_pkg::sum_t'(asc_pkg::SMOOTH_TAPS - 1) : '0);
    smp     = sum_rnd[asc_pkg::SUM_W-1:asc_pkg::SMOOTH_SHIFT];
  end

  // Window: midpoint threshold on rollover, then take in the smoothed word
  always_comb begin
    mid_sum = {max_q[asc_pkg::SAMPLE_W-1], max_q} + {min_q[asc_pkg::SAMPLE_W-1], min_q};
    mid_adj = mid_sum + {{asc_pkg::SAMPLE_W{1'b0}}, mid_sum[asc_pkg::SAMPLE_W]};
    if (ctl_i.roll) begin
      thr_d    = mid_adj[asc_pkg::SAMPLE_W:1];
      max_base = asc_pkg::SAMPLE_MIN;
      min_base = asc_pkg::SAMPLE_MAX;
    end else begin
      thr_d    = thr_q;
      max_base = max_q;
      min_base = min_q;
    end
    max_d = (smp > max_base) ? smp : max_base;
    min_d = (smp < min_base) ? smp : min_base;
  end

  // Gate: admit the word only when its change exceeds the precision
  always_comb begin
    diff   = {smp[asc_pkg::SAMPLE_W-1], smp} - {gcur_q[asc_pkg::SAMPLE_W-1], gcur_q};
    mag    = diff[asc_pkg::SAMPLE_W] ? -diff : diff;
    gcur_d = (mag > {1'b0, precision_i}) ? smp : gcur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '0;
      min_q   <= '0;
      thr_q   <= '0;
      gcur_q  <= '0;
      gprev_q <= '0;
    end else if (ctl_i.load_s2) begin
      max_q   <= max_d;
      min_q   <= min_d;
      thr_q   <= thr_d;
      gcur_q  <= gcur_d;
      gprev_q <= gcur_q;
    end
  end

  assign state_o.win_max   = max_q;
  assign state_o.win_min   = min_q;
  assign state_o.thr       = thr_q;
  assign state_o.gate_cur  = gcur_q;
  assign state_o.gate_prev = gprev_q;

endmodule

`default_nettype wire

[rtl/asc_merge.sv]
// Merge stage: picks the most active axis across lanes and detects a step.
// Holds the step counters and the output word register. Uses asc_pkg.
`default_nettype none

module asc_merge (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     load_i,
  input  wire                     screen_off_i,
  input  asc_pkg::cfg_word_t      active_min_i,
  input  asc_pkg::lane_state_t    lanes_i [asc_pkg::NUM_AXES],
  output logic                    step_seen_o,
  output logic [asc_pkg::TOTAL_W-1:0] total_steps_o,
  output logic [asc_pkg::IDLE_W-1:0]  idle_steps_o,
  output asc_pkg::axis_e          lead_axis_o
);

  logic signed [asc_pkg::SAMPLE_W:0] diff [asc_pkg::NUM_AXES];
  logic [asc_pkg::SAMPLE_W:0]        rabs [asc_pkg::NUM_AXES];
  logic [asc_pkg::REG_W-1:0]         rng  [asc_pkg::NUM_AXES];
  asc_pkg::axis_e                    axis;
  asc_pkg::lane_state_t              sel;
  logic                              step;

  logic                              step_q;
  asc_pkg::axis_e                    axis_q;
  logic [asc_pkg::TOTAL_W-1:0]       total_q;
  logic [asc_pkg::IDLE_W-1:0]        idle_q;

  // Window range of each lane
  always_comb begin
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      diff[a] = {lanes_i[a].win_max[asc_pkg::SAMPLE_W-1], lanes_i[a].win_max}
              - {lanes_i[a].win_min[asc_pkg::SAMPLE_W-1], lanes_i[a].win_min};
      rabs[a] = diff[a][asc_pkg::SAMPLE_W] ? -diff[a] : diff[a];
      rng[a]  = rabs[a][asc_pkg::REG_W-1:0];
    end
  end

  // Strictly largest range at or above the minimum wins; ties give none
  always_comb begin
    axis = asc_pkg::AXIS_NONE;
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      if (rng[a] > rng[(a + 1) % 3] && rng[a] > rng[(a + 2) % 3] &&
          rng[a] >= active_min_i) begin
        axis = asc_pkg::axis_e'(2'(a + 1));
      end
    end
  end

  // Downward threshold crossing on the chosen axis
  always_comb begin
    unique case (axis)
      asc_pkg::AXIS_X: sel = lanes_i[0];
      asc_pkg::AXIS_Y: sel = lanes_i[1];
      asc_pkg::AXIS_Z: sel = lanes_i[2];
      default:         sel = lanes_i[0];
    endcase
    step = (axis != asc_pkg::AXIS_NONE) &&
           (sel.gate_prev > sel.thr) && (sel.gate_cur < sel.thr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      idle_q  <= '0;
    end else if (load_i && step) begin
      total_q <= total_q + 1'b1;
      if (screen_off_i) begin
        idle_q <= idle_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      step_q <= step;
      axis_q <= axis;
    end
  end

  assign step_seen_o   = step_q;
  assign total_steps_o = total_q;
  assign idle_steps_o  = idle_q;
  assign lead_axis_o   = axis_q;

endmodule

`default_nettype wire

[rtl/accel_step_counter_top.sv]
// Accelerometer step counter: three axis lanes side by side and a merge stage.
// A sample word is registered in the smoother stage, then in the window and gate
// stage, then in the result word register. Throughput: one word per cycle unless
// stalled; input stalls only when all three stages are full and the result word
// is stalled. Reset (async, active low) clears counters, smoother taps, window and
// gate state and loads the register defaults. Uses asc_pkg, asc_lane, asc_merge.
`default_nettype none

module accel_step_counter_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration write channel
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [asc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [asc_pkg::REG_W-1:0]     cfg_data_i,
  // sample channel
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire signed [15:0]            accel_x_i,
  input  wire signed [15:0]            accel_y_i,
  input  wire signed [15:0]            accel_z_i,
  input  wire                          screen_off_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         step_seen_o,
  output logic [31:0]                  total_steps_o,
  output logic [7:0]                   idle_steps_o,
  output logic [1:0]                   lead_axis_o
);

  asc_pkg::cfg_word_t win_len_q, prec_x_q, prec_y_q, prec_z_q, act_min_q;

  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_off_q, s2_off_q;
  logic adv1, adv2, adv3, acc, load2, load3;
  logic [asc_pkg::TAP_IDX_W-1:0] wr_idx_q;
  logic [asc_pkg::REG_W-1:0]     win_cnt_q;
  logic                          roll;

  asc_pkg::lane_ctl_t    ctl;
  asc_pkg::lane_state_t  lanes [asc_pkg::NUM_AXES];
  asc_pkg::axis_e        axis;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= asc_pkg::WINDOW_LENGTH_RST;
      prec_x_q  <= asc_pkg::PRECISION_X_RST;
      prec_y_q  <= asc_pkg::PRECISION_Y_RST;
      prec_z_q  <= asc_pkg::PRECISION_Z_RST;
      act_min_q <= asc_pkg::ACTIVE_MINIMUM_RST;
    end else if (cfg_valid_i) begin
      unique case (asc_pkg::cfg_reg_e'(cfg_index_i))
        asc_pkg::CFG_WINDOW_LENGTH:  win_len_q <= cfg_data_i;
        asc_pkg::CFG_PRECISION_X:    prec_x_q  <= cfg_data_i;
        asc_pkg::CFG_PRECISION_Y:    prec_y_q  <= cfg_data_i;
        asc_pkg::CFG_PRECISION_Z:    prec_z_q  <= cfg_data_i;
        asc_pkg::CFG_ACTIVE_MINIMUM: act_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage advance: a stage moves when it is empty or its successor moves
  assign adv3  = !out_v_q || !out_stall_i;
  assign adv2  = !s2_v_q || adv3;
  assign adv1  = !s1_v_q || adv2;
  assign acc   = in_valid_i && adv1;
  assign load2 = s1_v_q && adv2;
  assign load3 = s2_v_q && adv3;

  assign in_stall_o  = !adv1;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q  <= acc;
      if (adv2) s2_v_q  <= s1_v_q;
      if (adv3) out_v_q <= s2_v_q;
    end
  end

  // Carry the screen flag alongside the word
  always_ff @(posedge clk_i) begin
    if (acc)   s1_off_q <= screen_off_i;
    if (load2) s2_off_q <= s1_off_q;
  end

  // Smoother write pointer and window counter
  assign roll = (win_cnt_q >= win_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      win_cnt_q <= '0;
    end else begin
      if (acc) wr_idx_q <= wr_idx_q + 1'b1;
      if (load2) begin
        win_cnt_q <= roll ? asc_pkg::cfg_word_t'(1) : win_cnt_q + 1'b1;
      end
    end
  end

  assign ctl.load_s1 = acc;
  assign ctl.load_s2 = load2;
  assign ctl.roll    = roll;
  assign ctl.wr_idx  = wr_idx_q;

  asc_lane u_lane_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sample_i    (accel_x_i),
    .precision_i (prec_x_q),
    .state_o     (lanes[0])
  );

  asc_lane u_lane_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sample_i    (accel_y_i),
    .precision_i (prec_y_q),
    .state_o     (lanes[1])
  );

  asc_lane u_lane_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sample_i    (accel_z_i),
    .precision_i (prec_z_q),
    .state_o     (lanes[2])
  );

  asc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load3),
    .screen_off_i  (s2_off_q),
    .active_min_i  (act_min_q),
    .lanes_i       (lanes),
    .step_seen_o   (step_seen_o),
    .total_steps_o (total_steps_o),
    .idle_steps_o  (idle_steps_o),
    .lead_axis_o   (axis)
  );

  assign lead_axis_o = axis;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for accel_step_counter_top: random and directed sample
// words, with a local pedometer predictor and a result checker. Depends on asc_pkg.
`default_nettype none

module tb;

  localparam int                 CLK_PERIOD     = 8;
  localparam int                 DRAIN_CYCLES   = 8;
  localparam int                 TIMEOUT_CYCLES = 400000;
  localparam asc_pkg::cfg_word_t REG_TOP        = '1;

  // Expected content of one result word
  typedef struct packed {
    logic           step_seen;
    logic [31:0]    total_steps;
    logic [7:0]     idle_steps;
    asc_pkg::axis_e lead_axis;
  } step_report_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [asc_pkg::CFG_IDX_W-1:0] cfg_index_i;
  asc_pkg::cfg_word_t            cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  asc_pkg::sample_t              accel_x_i;
  asc_pkg::sample_t              accel_y_i;
  asc_pkg::sample_t              accel_z_i;
  logic                          screen_off_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic                          step_seen_o;
  logic [31:0]                   total_steps_o;
  logic [7:0]                    idle_steps_o;
  logic [1:0]                    lead_axis_o;

  step_report_t pending_reports[$];
  int unsigned  mismatch_count = 0;
  bit           no_idle = 1'b0;

  // Predictor state
  asc_pkg::cfg_word_t win_len;
  asc_pkg::cfg_word_t prec[asc_pkg::NUM_AXES];
  asc_pkg::cfg_word_t act_min;
  int                 tap_mem[asc_pkg::SMOOTH_TAPS][asc_pkg::NUM_AXES];
  int unsigned        tap_ptr;
  int unsigned        win_count;
  int                 win_hi[asc_pkg::NUM_AXES];
  int                 win_lo[asc_pkg::NUM_AXES];
  int                 thr[asc_pkg::NUM_AXES];
  int                 gate_now[asc_pkg::NUM_AXES];
  int                 gate_old[asc_pkg::NUM_AXES];
  logic [31:0]        step_total;
  logic [7:0]         idle_total;

  accel_step_counter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .screen_off_i  (screen_off_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .step_seen_o   (step_seen_o),
    .total_steps_o (total_steps_o),
    .idle_steps_o  (idle_steps_o),
    .lead_axis_o   (lead_axis_o)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Gap lengths: mostly none or short, a few long
  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic asc_pkg::sample_t clamp_sample(input int v);
    if (v > int'(asc_pkg::SAMPLE_MAX)) return asc_pkg::SAMPLE_MAX;
    if (v < int'(asc_pkg::SAMPLE_MIN)) return asc_pkg::SAMPLE_MIN;
    return asc_pkg::sample_t'(v);
  endfunction

  function automatic void reset_pedometer();
    win_len = asc_pkg::WINDOW_LENGTH_RST;
    prec[0] = asc_pkg::PRECISION_X_RST;
    prec[1] = asc_pkg::PRECISION_Y_RST;
    prec[2] = asc_pkg::PRECISION_Z_RST;
    act_min = asc_pkg::ACTIVE_MINIMUM_RST;
    tap_ptr = 0;
    win_count = 0;
    step_total = '0;
    idle_total = '0;
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      for (int t = 0; t < asc_pkg::SMOOTH_TAPS; t++) tap_mem[t][a] = 0;
      win_hi[a] = 0;
      win_lo[a] = 0;
      thr[a] = 0;
      gate_now[a] = 0;
      gate_old[a] = 0;
    end
  endfunction

  function automatic void apply_reg(input logic [asc_pkg::CFG_IDX_W-1:0] idx,
                                    input asc_pkg::cfg_word_t val);
    case (idx)
      asc_pkg::CFG_WINDOW_LENGTH:  win_len = val;
      asc_pkg::CFG_PRECISION_X:    prec[0] = val;
      asc_pkg::CFG_PRECISION_Y:    prec[1] = val;
      asc_pkg::CFG_PRECISION_Z:    prec[2] = val;
      asc_pkg::CFG_ACTIVE_MINIMUM: act_min = val;
      default: ;
    endcase
  endfunction

  // Advance the predictor by one sample word and return the result it causes
  function automatic step_report_t predict_pedometer(input asc_pkg::sample_t x, y, z,
                                                     input logic off);
    int             raw[asc_pkg::NUM_AXES];
    int             avg[asc_pkg::NUM_AXES];
    int             span[asc_pkg::NUM_AXES];
    int             sum;
    int             diff;
    int             k;
    asc_pkg::axis_e lead;
    step_report_t   rep;
    raw[0] = x;
    raw[1] = y;
    raw[2] = z;
    lead = asc_pkg::AXIS_NONE;
    rep.step_seen = 1'b0;

    // Moving sum, truncated toward zero
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) tap_mem[tap_ptr][a] = raw[a];
    tap_ptr = (tap_ptr + 1) % asc_pkg::SMOOTH_TAPS;
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      sum = 0;
      for (int t = 0; t < asc_pkg::SMOOTH_TAPS; t++) sum += tap_mem[t][a];
      avg[a] = sum / int'(asc_pkg::SMOOTH_TAPS);
    end

    // Roll the window over into new thresholds, or keep counting
    if (win_count >= win_len) begin
      for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
        thr[a] = (win_hi[a] + win_lo[a]) / 2;
        win_hi[a] = asc_pkg::SAMPLE_MIN;
        win_lo[a] = asc_pkg::SAMPLE_MAX;
      end
      win_count = 1;
    end else begin
      win_count++;
    end
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      if (avg[a] > win_hi[a]) win_hi[a] = avg[a];
      if (avg[a] < win_lo[a]) win_lo[a] = avg[a];
    end

    // Change gate: previous always follows, current only on a large move
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      diff = avg[a] - gate_now[a];
      if (diff < 0) diff = -diff;
      gate_old[a] = gate_now[a];
      if (diff > int'(prec[a])) gate_now[a] = avg[a];
    end

    // Most active axis: strictly widest range, at least the minimum
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      span[a] = win_hi[a] - win_lo[a];
      if (span[a] < 0) span[a] = -span[a];
    end
    for (int a = 0; a < asc_pkg::NUM_AXES; a++) begin
      if (span[a] > span[(a + 1) % asc_pkg::NUM_AXES] &&
          span[a] > span[(a + 2) % asc_pkg::NUM_AXES] &&
          span[a] >= int'(act_min))
        lead = asc_pkg::axis_e'(2'(a + 1));
    end

    // Count a downward crossing of the lead axis threshold
    if (lead != asc_pkg::AXIS_NONE) begin
      k = int'(lead) - 1;
      if (gate_old[k] > thr[k] && gate_now[k] < thr[k]) begin
        rep.step_seen = 1'b1;
        step_total++;
        if (off) idle_total++;
      end
    end
    rep.total_steps = step_total;
    rep.idle_steps = idle_total;
    rep.lead_axis = lead;
    return rep;
  endfunction

  // Send one sample word; hold valid high when no gap is due
  task automatic send_sample(input asc_pkg::sample_t x, y, z, input logic off);
    int gap;
    gap = no_idle ? 0 : pick_gap_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i <= x;
    accel_y_i <= y;
    accel_z_i <= z;
    screen_off_i <= off;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_reports.push_back(predict_pedometer(x, y, z, off));
  endtask

  // Drop valid and wait until every expected result word is back
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [asc_pkg::CFG_IDX_W-1:0] idx,
                           input asc_pkg::cfg_word_t val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all_regs(input asc_pkg::cfg_word_t wl, px, py, pz, am);
    write_reg(asc_pkg::CFG_WINDOW_LENGTH, wl);
    write_reg(asc_pkg::CFG_PRECISION_X, px);
    write_reg(asc_pkg::CFG_PRECISION_Y, py);
    write_reg(asc_pkg::CFG_PRECISION_Z, pz);
    write_reg(asc_pkg::CFG_ACTIVE_MINIMUM, am);
  endtask

  // Triangle wave on one axis, the other two near a random level
  task automatic walk_burst(input int count);
    int               lead_sel;
    int               period;
    int               half;
    int               amp;
    int               offset;
    int               jitter;
    int               ph;
    int               v;
    int               level[asc_pkg::NUM_AXES];
    asc_pkg::sample_t s[asc_pkg::NUM_AXES];
    lead_sel = $urandom_range(asc_pkg::NUM_AXES - 1);
    period = 2 * $urandom_range(12, 3);
    half = period / 2;
    amp = $urandom_range(16000, 2000);
    offset = int'($urandom_range(16000)) - 8000;
    jitter = $urandom_range(600);
    for (int a = 0; a < asc_pkg::NUM_AXES; a++)
      level[a] = int'($urandom_range(20000)) - 10000;
    for (int i = 0; i < count; i++) begin
      ph = i % period;
      for (int a = 0; a < asc_pkg::NUM_AXES; a++)
        s[a] = clamp_sample(level[a] + int'($urandom_range(2 * jitter)) - jitter);
      if (ph < half) v = offset - amp + (2 * amp * ph) / half;
      else v = offset + amp - (2 * amp * (ph - half)) / half;
      s[lead_sel] = clamp_sample(v + int'($urandom_range(jitter)));
      send_sample(s[0], s[1], s[2], 1'($urandom_range(1)));
    end
  endtask

  task automatic noise_burst(input int count);
    for (int i = 0; i < count; i++)
      send_sample(asc_pkg::sample_t'($urandom), asc_pkg::sample_t'($urandom),
                  asc_pkg::sample_t'($urandom), 1'($urandom_range(1)));
  endtask

  // Partial smoother fill after reset and the extremes of the sample fields;
  // equal values on all axes leave no active axis
  task automatic test_fill_and_extremes();
    send_sample(asc_pkg::SAMPLE_MAX, asc_pkg::SAMPLE_MAX, asc_pkg::SAMPLE_MAX, 1'b0);
    send_sample(asc_pkg::SAMPLE_MIN, asc_pkg::SAMPLE_MIN, asc_pkg::SAMPLE_MIN, 1'b1);
    send_sample(asc_pkg::SAMPLE_MAX, asc_pkg::SAMPLE_MIN, '0, 1'b1);
    send_sample(asc_pkg::SAMPLE_MIN, asc_pkg::SAMPLE_MAX,
                asc_pkg::sample_t'(16'hAAAA), 1'b0);
    send_sample(asc_pkg::sample_t'(16'h5555), asc_pkg::sample_t'(16'hAAAA),
                asc_pkg::SAMPLE_MAX, 1'b1);
    send_sample('0, '0, '0, 1'b1);
  endtask

  // Unused register index, zero-length window and register extremes
  task automatic test_register_corners();
    logic [asc_pkg::CFG_IDX_W-1:0] bad_idx;
    wait_results_drained();
    bad_idx = asc_pkg::CFG_ACTIVE_MINIMUM + asc_pkg::CFG_IDX_W'($urandom_range(3, 1));
    write_reg(bad_idx, asc_pkg::cfg_word_t'($urandom));
    write_all_regs('0, '0, '0, '0, '0);
    send_sample(asc_pkg::SAMPLE_MAX, '0, '0, 1'b1);
    send_sample(asc_pkg::SAMPLE_MIN, '0, '0, 1'b1);
    send_sample(asc_pkg::SAMPLE_MAX, asc_pkg::SAMPLE_MIN, '0, 1'b0);
    send_sample('0, '0, asc_pkg::SAMPLE_MIN, 1'b1);
    wait_results_drained();
    write_all_regs(REG_TOP, REG_TOP, REG_TOP, REG_TOP, REG_TOP);
    send_sample(asc_pkg::SAMPLE_MIN, asc_pkg::SAMPLE_MAX, '0, 1'b1);
    send_sample(asc_pkg::SAMPLE_MAX, asc_pkg::SAMPLE_MIN, asc_pkg::SAMPLE_MIN, 1'b1);
    send_sample('0, '0, '0, 1'b0);
  endtask

  // Shorten the window below the running count: roll over on the next word
  task automatic test_window_shortened();
    wait_results_drained();
    write_all_regs(16'd30, 16'd500, 16'd500, 16'd500, 16'd1000);
    walk_burst(10);
    wait_results_drained();
    write_reg(asc_pkg::CFG_WINDOW_LENGTH, 16'd3);
    walk_burst(3);
  endtask

  // Phases of walking waveforms and noise under several register settings
  task automatic test_random_walking();
    int quota;
    int sent;
    int n;
    bit paused;
    for (int p = 0; p < 10; p++) begin
      wait_results_drained();
      if (p == 0) begin
        write_all_regs(16'd1, '0, '0, '0, '0);
        quota = 50;
      end else if (p == 1) begin
        write_all_regs(REG_TOP, REG_TOP, REG_TOP, REG_TOP, REG_TOP);
        quota = 20;
      end else begin
        write_all_regs(($urandom_range(3) == 0) ? asc_pkg::cfg_word_t'($urandom_range(3))
                                                : asc_pkg::cfg_word_t'($urandom_range(64, 6)),
                       asc_pkg::cfg_word_t'($urandom_range(3000)),
                       asc_pkg::cfg_word_t'($urandom_range(3000)),
                       asc_pkg::cfg_word_t'($urandom_range(3000)),
                       asc_pkg::cfg_word_t'($urandom_range(8000)));
        quota = 48;
      end
      if ($urandom_range(1))
        write_reg(asc_pkg::CFG_ACTIVE_MINIMUM + asc_pkg::CFG_IDX_W'($urandom_range(3, 1)),
                  asc_pkg::cfg_word_t'($urandom));
      sent = 0;
      paused = 1'b0;
      while (sent < quota) begin
        no_idle = ($urandom_range(3) == 0);
        if ($urandom_range(3) != 0) begin
          n = $urandom_range(48, 16);
          if (n > quota - sent) n = quota - sent;
          walk_burst(n);
        end else begin
          n = $urandom_range(10, 3);
          if (n > quota - sent) n = quota - sent;
          noise_burst(n);
        end
        sent += n;
        // Hold the sender until the pipeline is empty, then resume
        if (!paused && sent >= quota / 2 && (p == 2 || $urandom_range(1))) begin
          paused = 1'b1;
          wait_results_drained();
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Receiver side: random stall stretches
  initial begin
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = no_idle ? 0 : pick_gap_len();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    step_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result word, total_steps %0d", $time, total_steps_o);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (step_seen_o !== want.step_seen) begin
          $display("%0t: step_seen expected %0d got %0d", $time, want.step_seen, step_seen_o);
          mismatch_count++;
        end
        if (total_steps_o !== want.total_steps) begin
          $display("%0t: total_steps expected %0d got %0d", $time, want.total_steps,
                   total_steps_o);
          mismatch_count++;
        end
        if (idle_steps_o !== want.idle_steps) begin
          $display("%0t: idle_steps expected %0d got %0d", $time, want.idle_steps,
                   idle_steps_o);
          mismatch_count++;
        end
        if (lead_axis_o !== want.lead_axis) begin
          $display("%0t: lead_axis expected %0d got %0d", $time, want.lead_axis,
                   lead_axis_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("** accel_step_counter_top: FAILED **");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    accel_x_i = '0;
    accel_y_i = '0;
    accel_z_i = '0;
    screen_off_i = 1'b0;
    reset_pedometer();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill_and_extremes();
    test_register_corners();
    test_window_shortened();
    test_random_walking();
    wait_results_drained();

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("** accel_step_counter_top: PASSED **");
    end else begin
      $display("** accel_step_counter_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
